// ===== hw/rtl/ble_pkg.sv =====
package ble_pkg;

   localparam int KIND_W = 4;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_INS_HEAD = 4'd0;
   localparam logic [KIND_W-1:0] KIND_INS_TAIL = 4'd1;
   localparam logic [KIND_W-1:0] KIND_INS_POS  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 4'd4;
   localparam logic [KIND_W-1:0] KIND_DEL_POS  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DEL_KEY  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_SEARCH   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_REVERSE  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_DUMP     = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOKEY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

   // sequencer states
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_RD_A   = 10'b0000000010,
      S_WT_A   = 10'b0000000100,
      S_MOVE   = 10'b0000001000,
      S_SCAN   = 10'b0000010000,
      S_REV_B  = 10'b0000100000,
      S_REV_W  = 10'b0001000000,
      S_DUMP   = 10'b0010000000,
      S_FINISH = 10'b0100000000,
      S_PUT    = 10'b1000000000
   } state_type;

endpackage

// ===== hw/rtl/bounded_list_engine.sv =====
// shifting inserts/deletes and reverse walk the store one entry at a time
//   through its single registered read port
// throughput: one operation at a time, busy stays high through the final beat
// dump gives one beat per entry, one per cycle after each read
// reset: synchronous active high, clears count and sequencer; no store clear
// the receiver cannot stall, rsp_valid marks each beat for one cycle
module bounded_list_engine #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ble_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ble_pkg::VALUE_W-1:0]  req_value,
   input  logic [$clog2(DEPTH+1)-1:0]          req_position,
   output logic                                rsp_valid,
   output logic [ble_pkg::STATUS_W-1:0]        rsp_status,
   output logic [$clog2(DEPTH)-1:0]            rsp_index_out,
   output logic signed [ble_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_length,
   output logic                                rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   ble_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ble_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [ble_pkg::VALUE_W-1:0] val_ff, val_in;
   // walking pointers: i forward (backward for inserts), j backward
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, end_ff, end_in;
   logic [ble_pkg::VALUE_W-1:0] hold_ff, hold_in;
   logic [ble_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic ins_ff, ins_in;

   logic rv_ff, rv_in, rl_ff, rl_in;
   logic [ble_pkg::STATUS_W-1:0] rs_ff, rs_in;
   logic [IDX_W-1:0] ri_ff, ri_in;
   logic [ble_pkg::VALUE_W-1:0] re_ff, re_in;
   logic [CNT_W-1:0] rc_ff, rc_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [ble_pkg::VALUE_W-1:0] wr_data, rd_data;

   ble_store #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; kind_in = kind_ff; val_in = val_ff;
      i_in = i_ff; j_in = j_ff; end_in = end_ff; hold_in = hold_ff;
      st_in = st_ff; idx_in = idx_ff; ins_in = ins_ff;
      rv_in = 1'b0; rl_in = 1'b0; rs_in = rs_ff; ri_in = ri_ff; re_in = re_ff;
      rc_in = rc_ff;
      wr_en = 1'b0; wr_addr = i_ff[IDX_W-1:0]; wr_data = hold_ff;
      rd_addr = i_ff[IDX_W-1:0];
      case (state_ff)
         ble_pkg::S_IDLE: begin
            // the last beat still in the output register keeps busy high
            if (start && !rv_ff) begin
               kind_in = req_kind; val_in = req_value;
               st_in = ble_pkg::ST_OK; idx_in = '0; state_in = ble_pkg::S_FINISH;
               case (req_kind)
                  ble_pkg::KIND_INS_HEAD, ble_pkg::KIND_INS_TAIL,
                  ble_pkg::KIND_INS_POS: begin
                     if (count_ff >= DEPTH_C) st_in = ble_pkg::ST_FULL;
                     else if (req_kind == ble_pkg::KIND_INS_POS &&
                              req_position > count_ff) st_in = ble_pkg::ST_BADPOS;
                     else begin
                        // shift up from the tail down to the target slot
                        ins_in = 1'b1;
                        end_in = (req_kind == ble_pkg::KIND_INS_HEAD) ? '0 :
                                 (req_kind == ble_pkg::KIND_INS_TAIL) ? count_ff :
                                 req_position;
                        i_in = count_ff;
                        state_in = ble_pkg::S_MOVE;
                     end
                  end
                  ble_pkg::KIND_DEL_HEAD, ble_pkg::KIND_DEL_TAIL,
                  ble_pkg::KIND_DEL_POS: begin
                     if (count_ff == '0) st_in = ble_pkg::ST_EMPTY;
                     else if (req_kind == ble_pkg::KIND_DEL_TAIL)
                        count_in = count_ff - 1'b1;
                     else if (req_kind == ble_pkg::KIND_DEL_POS &&
                              req_position >= count_ff) st_in = ble_pkg::ST_BADPOS;
                     else begin
                        ins_in = 1'b0;
                        i_in = (req_kind == ble_pkg::KIND_DEL_HEAD) ? '0 : req_position;
                        state_in = ble_pkg::S_MOVE;
                     end
                  end
                  ble_pkg::KIND_DEL_KEY, ble_pkg::KIND_SEARCH: begin
                     if (count_ff == '0) st_in = (req_kind == ble_pkg::KIND_DEL_KEY) ?
                                                 ble_pkg::ST_EMPTY : ble_pkg::ST_NOKEY;
                     else begin
                        i_in = '0; state_in = ble_pkg::S_RD_A;
                     end
                  end
                  ble_pkg::KIND_REVERSE: begin
                     if (count_ff > CNT_W'(1)) begin
                        i_in = '0; j_in = count_ff - 1'b1; state_in = ble_pkg::S_RD_A;
                     end
                  end
                  ble_pkg::KIND_DUMP: begin
                     if (count_ff == '0) st_in = ble_pkg::ST_EMPTY;
                     else begin
                        i_in = '0; state_in = ble_pkg::S_RD_A;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // address issued this cycle, data next
         ble_pkg::S_RD_A: begin
            rd_addr = i_ff[IDX_W-1:0];
            state_in = ble_pkg::S_WT_A;
            if (kind_ff == ble_pkg::KIND_DUMP) state_in = ble_pkg::S_DUMP;
            else if (kind_ff == ble_pkg::KIND_REVERSE) state_in = ble_pkg::S_REV_B;
            else state_in = ble_pkg::S_SCAN;
         end
         ble_pkg::S_SCAN: begin
            if (rd_data == val_ff) begin
               idx_in = i_ff[IDX_W-1:0];
               if (kind_ff == ble_pkg::KIND_DEL_KEY) begin
                  ins_in = 1'b0; state_in = ble_pkg::S_MOVE; idx_in = '0;
               end else state_in = ble_pkg::S_FINISH;
            end else if (i_ff + 1'b1 >= count_ff) begin
               st_in = ble_pkg::ST_NOKEY; state_in = ble_pkg::S_FINISH;
            end else begin
               i_in = i_ff + 1'b1; rd_addr = i_in[IDX_W-1:0];
               state_in = ble_pkg::S_SCAN;
            end
            if (state_in == ble_pkg::S_SCAN) rd_addr = i_in[IDX_W-1:0];
         end
         // one shift step: read neighbor, then write it in S_WT_A
         ble_pkg::S_MOVE: begin
            if (ins_ff) begin
               if (i_ff == end_ff) begin
                  wr_en = 1'b1; wr_data = val_ff;
                  count_in = count_ff + 1'b1; state_in = ble_pkg::S_FINISH;
               end else begin
                  rd_addr = IDX_W'(i_ff - 1'b1); state_in = ble_pkg::S_WT_A;
               end
            end else begin
               if (i_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1; state_in = ble_pkg::S_FINISH;
               end else begin
                  rd_addr = IDX_W'(i_ff + 1'b1); state_in = ble_pkg::S_WT_A;
               end
            end
         end
         ble_pkg::S_WT_A: begin
            wr_en = 1'b1; wr_data = rd_data;
            i_in = ins_ff ? i_ff - 1'b1 : i_ff + 1'b1;
            state_in = ble_pkg::S_MOVE;
         end
         // reverse: hold a[i], read a[j]
         ble_pkg::S_REV_B: begin
            hold_in = rd_data; rd_addr = j_ff[IDX_W-1:0];
            state_in = ble_pkg::S_REV_W;
         end
         ble_pkg::S_REV_W: begin
            wr_en = 1'b1; wr_addr = i_ff[IDX_W-1:0]; wr_data = rd_data;
            state_in = ble_pkg::S_PUT;
         end
         ble_pkg::S_PUT: begin
            wr_en = 1'b1; wr_addr = j_ff[IDX_W-1:0]; wr_data = hold_ff;
            i_in = i_ff + 1'b1; j_in = j_ff - 1'b1;
            if (i_ff + 1'b1 >= j_ff - 1'b1 || i_ff + 1'b1 > j_ff - 1'b1)
               state_in = ble_pkg::S_FINISH;
            else begin
               rd_addr = i_in[IDX_W-1:0]; state_in = ble_pkg::S_REV_B;
            end
            if (j_ff - i_ff <= CNT_W'(2)) state_in = ble_pkg::S_FINISH;
         end
         // one beat per entry, next read overlapped
         ble_pkg::S_DUMP: begin
            rv_in = 1'b1; rs_in = ble_pkg::ST_OK; ri_in = i_ff[IDX_W-1:0];
            re_in = rd_data; rc_in = count_ff;
            rl_in = (i_ff + 1'b1 == count_ff);
            i_in = i_ff + 1'b1; rd_addr = i_in[IDX_W-1:0];
            state_in = rl_in ? ble_pkg::S_IDLE : ble_pkg::S_DUMP;
         end
         ble_pkg::S_FINISH: begin
            rv_in = 1'b1; rl_in = 1'b1; rs_in = st_ff; ri_in = idx_ff;
            re_in = '0; rc_in = count_ff; state_in = ble_pkg::S_IDLE;
         end
         default: state_in = ble_pkg::S_IDLE;
      endcase
      if (state_ff == ble_pkg::S_MOVE && ins_ff) wr_addr = i_ff[IDX_W-1:0];
      if (state_ff == ble_pkg::S_WT_A) wr_addr = i_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ble_pkg::S_IDLE;
         count_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff <= rv_in;
      end
      kind_ff <= kind_in; val_ff <= val_in; i_ff <= i_in; j_ff <= j_in;
      end_ff <= end_in; hold_ff <= hold_in; st_ff <= st_in; idx_ff <= idx_in;
      ins_ff <= ins_in; rl_ff <= rl_in; rs_ff <= rs_in; ri_ff <= ri_in;
      re_ff <= re_in; rc_ff <= rc_in;
   end

   assign busy = (state_ff != ble_pkg::S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_index_out = ri_ff;
   assign rsp_entry_value = re_ff;
   assign rsp_length = rc_ff;
   assign rsp_last = rl_ff;

endmodule

// ===== hw/rtl/ble_store.sv =====
module ble_store #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [ble_pkg::VALUE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [ble_pkg::VALUE_W-1:0] rd_data
);

   logic [ble_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic [ble_pkg::VALUE_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int DEPTH = 16;
   localparam int POS_W = $clog2(DEPTH+1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int KIND_W = ble_pkg::KIND_W;
   localparam int VALUE_W = ble_pkg::VALUE_W;
   localparam int STATUS_W = ble_pkg::STATUS_W;
   localparam int LIMIT = 400000;
   localparam int N_RAND = 172;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index_out;
      logic [VALUE_W-1:0]  entry_value;
      logic [POS_W-1:0]    length;
      logic                last;
   } list_beat_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      bit                 has_fixed;
      list_beat_type      fixed;
   } list_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KIND_W-1:0] req_kind = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [POS_W-1:0] req_position = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0] rsp_index_out;
   logic signed [VALUE_W-1:0] rsp_entry_value;
   logic [POS_W-1:0] rsp_length;
   logic rsp_last;

   bounded_list_engine #(.DEPTH(DEPTH)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the list
   logic [VALUE_W-1:0] shadow_list [DEPTH];
   int shadow_count = 0;
   list_beat_type pending_beats [$];
   int mismatches = 0;
   int cycles = 0;
   list_cmd_type directed [$];

   function automatic list_beat_type mk(logic [STATUS_W-1:0] st, int idx,
                                        logic [VALUE_W-1:0] v, int len, bit lst);
      list_beat_type b;
      b.status = st; b.index_out = idx[IDX_W-1:0]; b.entry_value = v;
      b.length = len[POS_W-1:0]; b.last = lst;
      return b;
   endfunction

   // apply one command to the shadow list and queue the beats it causes
   task automatic predict_list_op(list_cmd_type c);
      logic [STATUS_W-1:0] st;
      int idx, p, f;
      logic [VALUE_W-1:0] t;
      st = ble_pkg::ST_OK; idx = 0; p = int'(c.position); f = -1;
      if (c.kind == ble_pkg::KIND_DEL_KEY || c.kind == ble_pkg::KIND_SEARCH)
         for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_list[i] == c.value) f = i;
      case (c.kind)
         ble_pkg::KIND_INS_HEAD, ble_pkg::KIND_INS_TAIL, ble_pkg::KIND_INS_POS: begin
            if (c.kind == ble_pkg::KIND_INS_HEAD) p = 0;
            if (c.kind == ble_pkg::KIND_INS_TAIL) p = shadow_count;
            if (shadow_count >= DEPTH) st = ble_pkg::ST_FULL;
            else if (p > shadow_count) st = ble_pkg::ST_BADPOS;
            else begin
               for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[p] = c.value;
               shadow_count++;
            end
         end
         ble_pkg::KIND_DEL_HEAD, ble_pkg::KIND_DEL_TAIL, ble_pkg::KIND_DEL_POS,
         ble_pkg::KIND_DEL_KEY: begin
            if (c.kind == ble_pkg::KIND_DEL_HEAD) p = 0;
            if (c.kind == ble_pkg::KIND_DEL_TAIL) p = shadow_count - 1;
            if (c.kind == ble_pkg::KIND_DEL_KEY) p = f;
            if (shadow_count == 0) st = ble_pkg::ST_EMPTY;
            else if (c.kind == ble_pkg::KIND_DEL_KEY && f < 0) st = ble_pkg::ST_NOKEY;
            else if (p >= shadow_count) st = ble_pkg::ST_BADPOS;
            else begin
               for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         ble_pkg::KIND_SEARCH: begin
            if (f < 0) st = ble_pkg::ST_NOKEY; else idx = f;
         end
         ble_pkg::KIND_REVERSE:
            for (int i = 0; i < shadow_count / 2; i++) begin
               t = shadow_list[i];
               shadow_list[i] = shadow_list[shadow_count-1-i];
               shadow_list[shadow_count-1-i] = t;
            end
         ble_pkg::KIND_DUMP: begin
            if (shadow_count == 0)
               pending_beats.push_back(mk(ble_pkg::ST_EMPTY, 0, '0, 0, 1'b1));
            for (int i = 0; i < shadow_count; i++)
               pending_beats.push_back(mk(ble_pkg::ST_OK, i, shadow_list[i], shadow_count,
                                          i + 1 == shadow_count));
            return;
         end
         default: ;
      endcase
      pending_beats.push_back(mk(st, idx, '0, shadow_count, 1'b1));
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      list_beat_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         got = mk(rsp_status, int'(rsp_index_out), rsp_entry_value, int'(rsp_length), rsp_last);
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", got);
         end else begin
            want = pending_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock)
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end

   // start is not lowered once the command is taken; it drops only before a random gap
   task automatic issue(list_cmd_type c);
      int gap;
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= c.kind;
      req_value <= c.value;
      req_position <= c.position;
      if (c.has_fixed) pending_beats.push_back(c.fixed);
      else predict_list_op(c);
      if (c.has_fixed) begin
         // keep the shadow list in step with typed-in rows
         void'(pending_beats.pop_back());
         predict_list_op(c);
         if (pending_beats[$] !== c.fixed) begin
            mismatches++;
            $display("table row disagrees with prediction kind %0d", c.kind);
         end
      end
      do @(posedge clock); while (busy);
   endtask

   function automatic list_cmd_type row(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v, int p);
      list_cmd_type c;
      c.kind = k; c.value = v; c.position = p[POS_W-1:0]; c.has_fixed = 0; c.fixed = '0;
      return c;
   endfunction

   function automatic list_cmd_type fixed_row(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
                                              int p, list_beat_type b);
      list_cmd_type c;
      c = row(k, v, p); c.has_fixed = 1; c.fixed = b;
      return c;
   endfunction

   function automatic list_cmd_type rand_cmd();
      list_cmd_type c;
      int r;
      r = $urandom_range(0, 99);
      c = row(ble_pkg::KIND_INS_HEAD, $urandom, $urandom_range(0, DEPTH));
      if (r < 45) c.kind = KIND_W'($urandom_range(0, 2));
      else if (r < 75) c.kind = KIND_W'($urandom_range(3, 6));
      else if (r < 95) c.kind = KIND_W'($urandom_range(7, 9));
      else c.kind = KIND_W'($urandom_range(10, 15));
      // reuse stored keys most of the time so searches hit
      if ((c.kind == ble_pkg::KIND_DEL_KEY || c.kind == ble_pkg::KIND_SEARCH) &&
          shadow_count > 0 && $urandom_range(0, 3) != 0)
         c.value = shadow_list[$urandom_range(0, shadow_count - 1)];
      if ($urandom_range(0, 9) == 0) c.position = POS_W'($urandom_range(0, 31));
      return c;
   endfunction

   initial begin
      list_cmd_type c;
      // directed table
      directed.push_back(fixed_row(ble_pkg::KIND_DUMP, '0, 0,
                                   mk(ble_pkg::ST_EMPTY, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_DEL_HEAD, '0, 0,
                                   mk(ble_pkg::ST_EMPTY, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_DEL_TAIL, '0, 0,
                                   mk(ble_pkg::ST_EMPTY, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_DEL_POS, '0, 0,
                                   mk(ble_pkg::ST_EMPTY, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_DEL_KEY, '0, 0,
                                   mk(ble_pkg::ST_EMPTY, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_SEARCH, '0, 0,
                                   mk(ble_pkg::ST_NOKEY, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_REVERSE, '0, 0,
                                   mk(ble_pkg::ST_OK, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_INS_POS, 32'h5, 1,
                                   mk(ble_pkg::ST_BADPOS, 0, '0, 0, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_INS_TAIL, 32'h8000_0000, 0,
                                   mk(ble_pkg::ST_OK, 0, '0, 1, 1)));
      directed.push_back(fixed_row(ble_pkg::KIND_DEL_TAIL, '0, 0,
                                   mk(ble_pkg::ST_OK, 0, '0, 0, 1)));
      directed.push_back(row(ble_pkg::KIND_INS_HEAD, 32'h7FFF_FFFF, 0));
      directed.push_back(row(ble_pkg::KIND_INS_POS, 32'hFFFF_FFFF, 1));
      directed.push_back(row(ble_pkg::KIND_INS_POS, 32'h0, 0));
      directed.push_back(row(ble_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 0));
      directed.push_back(row(ble_pkg::KIND_DEL_POS, '0, 3));
      directed.push_back(row(ble_pkg::KIND_REVERSE, '0, 0));
      directed.push_back(row(ble_pkg::KIND_DUMP, '0, 0));
      directed.push_back(row(ble_pkg::KIND_DEL_KEY, 32'h7FFF_FFFF, 0));
      directed.push_back(row(ble_pkg::KIND_DEL_KEY, 32'h1234, 0));
      directed.push_back(row(4'd15, 32'hFFFF_FFFF, 31));
      for (int i = 0; i < 15; i++) directed.push_back(row(ble_pkg::KIND_INS_TAIL, $urandom, 0));
      directed.push_back(fixed_row(ble_pkg::KIND_INS_POS, 32'h1, 31,
                                   mk(ble_pkg::ST_FULL, 0, '0, 16, 1)));
      directed.push_back(row(ble_pkg::KIND_DUMP, '0, 0));
      directed.push_back(row(ble_pkg::KIND_DEL_POS, '0, 15));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) issue(directed[i]);
      for (int n = 0; n < N_RAND; n++) begin
         // one hold-off until the engine has drained
         if (n == N_RAND / 2) begin
            start <= 1'b0;
            while (pending_beats.size() != 0) @(posedge clock);
         end
         c = rand_cmd();
         issue(c);
      end
      start <= 1'b0;
      while (pending_beats.size() != 0 || busy) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && pending_beats.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ble_pkg.sv
hw/rtl/ble_store.sv
hw/rtl/bounded_list_engine.sv
tb/testbench.sv
